// ----- src/cfbs_pkg.sv -----
// Shared types, reset constants and the CRC byte fold for the framed byte sender.
// No dependencies; every other file of the block but the checker imports this package.
package cfbs_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] POLY_RESET  = 16'hA001;
    localparam logic [15:0] START_RESET = 16'hFFFF;
    localparam logic [7:0]  END_RESET   = 8'h03;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLY  = 2'd0,
        CFG_START = 2'd1,
        CFG_END   = 2'd2
    } t_cfg_idx;

    // one classified item as it waits between front and back
    typedef struct packed {
        logic        is_end;
        logic [7:0]  data;
        logic [15:0] inv_crc;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue_head;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_HIGH,
        PH_END
    } t_phase;

    // xor the byte into the low bits, then eight reflected shift steps
    function automatic logic [15:0] fold_byte(input logic [15:0] crc,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
        logic [15:0] c;
        logic        dropped;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            dropped = c[0];
            c = {1'b0, c[15:1]};
            if (dropped) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/cfbs_front.sv -----
// Front end: configuration registers, end-code classification and running CRC.
// Depends on cfbs_pkg for the register codes, the entry type and fold_byte.
module cfbs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic [7:0]                     i_data_byte,
    output cfbs_pkg::t_entry               o_entry
);
    import cfbs_pkg::*;

    logic [15:0] r_poly;
    logic [15:0] r_start;
    logic [7:0]  r_end_code;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly     <= POLY_RESET;
            r_start    <= START_RESET;
            r_end_code <= END_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_POLY:  r_poly     <= i_cfg_data[15:0];
                CFG_START: r_start    <= i_cfg_data[15:0];
                CFG_END:   r_end_code <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign is_end = (i_data_byte == r_end_code);

    always_comb begin
        n_crc = r_crc;
        if (i_accept) begin
            n_crc = is_end ? r_start : fold_byte(r_crc, i_data_byte, r_poly);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= START_RESET;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_entry.is_end  = is_end;
    assign o_entry.data    = i_data_byte;
    assign o_entry.inv_crc = ~r_crc;

endmodule

// ----- src/cfbs_queue.sv -----
// Short queue of classified items between front and back.
// Depends on cfbs_pkg for the entry and head types.
module cfbs_queue #(
    parameter int unsigned DEPTH = cfbs_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cfbs_pkg::t_entry      i_entry,
    input  logic                  i_deq,
    output logic                  o_full,
    output cfbs_pkg::t_queue_head o_head
);
    import cfbs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_deq;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_deq  = i_deq && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_deq) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_deq) begin
            n_count = r_count + 1'b1;
        end else if (do_deq && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

endmodule

// ----- src/cfbs_back.sv -----
// Back end: expands queued items into result bytes and holds the output register.
// Depends on cfbs_pkg for the head type and the phase enum.
module cfbs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfbs_pkg::t_queue_head i_head,
    output logic                  o_deq,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);
    import cfbs_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        load;
    logic [7:0]  sel_byte;
    logic        sel_last;
    logic        sel_done;

    assign load = i_head.valid && (!r_out_valid || i_pop);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (load) begin
            if (sel_done) begin
                n_phase = PH_LOW;
            end else begin
                case (r_phase)
                    PH_LOW:  n_phase = PH_HIGH;
                    PH_HIGH: n_phase = PH_END;
                    default: n_phase = PH_LOW;
                endcase
            end
        end
    end

    // result selected for the current phase
    always_comb begin
        case (r_phase)
            PH_LOW: begin
                if (i_head.entry.is_end) begin
                    sel_byte = i_head.entry.inv_crc[7:0];
                    sel_last = 1'b0;
                    sel_done = 1'b0;
                end else begin
                    sel_byte = i_head.entry.data;
                    sel_last = 1'b1;
                    sel_done = 1'b1;
                end
            end
            PH_HIGH: begin
                sel_byte = i_head.entry.inv_crc[15:8];
                sel_last = 1'b0;
                sel_done = 1'b0;
            end
            default: begin
                sel_byte = i_head.entry.data;
                sel_last = 1'b1;
                sel_done = 1'b1;
            end
        endcase
    end

    assign o_deq = load && sel_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LOW;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= sel_byte;
            r_out_last <= sel_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

// ----- src/crc16_framed_byte_sender.sv -----
// Top level of the CRC-16 framed byte sender: front, item queue and back.
// Depends on cfbs_pkg, cfbs_front, cfbs_queue and cfbs_back.
//
// Push message bytes in; pop bytes for the serial line out. An ordinary byte is
// folded into a running reflected CRC-16 and passed through as one result with
// o_last set. The end code closes a frame and yields three results: the
// complemented CRC low byte, the complemented CRC high byte, then the end code
// with o_last set; the CRC then returns to the start value. An accepted item is
// written into the item queue and then loaded into the result register before it
// reaches the result ports. The input takes one item per cycle while the item
// queue (QUEUE_DEPTH entries) has room; the output delivers one result per cycle
// while results are popped, so ordinary bytes are sustained at one item per cycle
// and an end code holds the single result register for its three results. Write
// configuration only while idle; a new start value applies at the next frame end.
module crc16_framed_byte_sender #(
    parameter int unsigned QUEUE_DEPTH = cfbs_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cfbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_data_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last
);
    import cfbs_pkg::*;

    t_entry      front_entry;
    t_queue_head queue_head;
    logic        accept;
    logic        deq;

    // an item enters when the queue has room
    assign accept = push && !full;

    cfbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_entry     (front_entry)
    );

    // hold classified items so front and back stall independently
    cfbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_deq   (deq),
        .o_full  (full),
        .o_head  (queue_head)
    );

    // expand each item into its result bytes
    cfbs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (queue_head),
        .o_deq      (deq),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

// ----- src/cfbs_checker.sv -----
// Port-level checks for the framed byte sender, bound to the top level.
// Depends only on the top level's ports.
module cfbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // reset leaves no result and room for input
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("results or full flag after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("waiting result changed");

    // the rest of a frame trailer follows at once
    a_trailer_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> !empty)
        else $error("gap inside frame trailer");

    // no result appears without an item pushed, once the queue has drained
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full)) ##1 (empty && !(push && !full)) |=> empty)
        else $error("result without input");

endmodule

bind crc16_framed_byte_sender cfbs_checker u_cfbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);
